FILE: hdl/pfi_pkg.sv
package pfi_pkg;

    localparam int unsigned PALETTE_COUNT_MAX = 16;
    localparam int unsigned ENTRIES_LOG2      = 4;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // one step per quotient bit of (frame_time * 256) / fade_frames
    localparam int unsigned DIV_STEPS = 17;
    localparam int unsigned DIV_CNT_W = 5;

    localparam logic [1:0] MODE_RESTART = 2'd0;
    localparam logic [1:0] MODE_TICK    = 2'd1;
    localparam logic [1:0] MODE_BLEND   = 2'd2;

    localparam logic [1:0] SRC_FIXED_TO_PAL = 2'd1;
    localparam logic [1:0] SRC_PAL_TO_FIXED = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_FADE_FRAMES   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SOURCE_MODE   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FIXED_COLOR   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PALETTE_COUNT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_USE_MASK      = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_PALETTE_MASK  = 3'd5;

    localparam logic [8:0] WEIGHT_ONE = 9'd256;

    typedef struct packed {
        logic req_load;
        logic exec;
        logic out_tick;
        logic div_start;
        logic div_step;
    } cmd_t;

    typedef struct packed {
        logic tick_div;
        logic div_last;
    } status_t;

    // c0 + floor((c1 - c0) * w / 256)
    function automatic logic [4:0] lerp_chan(input logic [4:0] c0, input logic [4:0] c1,
                                             input logic [8:0] w);
        logic signed [5:0]  d;
        logic signed [15:0] p;
        d = $signed({1'b0, c1}) - $signed({1'b0, c0});
        p = 16'(d) * 16'($signed({1'b0, w}));
        return c0 + p[12:8];
    endfunction

    function automatic logic [14:0] lerp_color(input logic [14:0] from, input logic [14:0] to,
                                               input logic [8:0] w);
        logic [14:0] res;
        res = '0;
        for (int i = 0; i < 3; i++) begin
            res[i*5 +: 5] = lerp_chan(from[i*5 +: 5], to[i*5 +: 5], w);
        end
        return res;
    endfunction

endpackage

FILE: hdl/pfi_ctrl.sv
module pfi_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  pfi_pkg::status_t status,
    output pfi_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   req_valid_reg, req_valid_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   consume;

    assign out_free = !out_valid_reg || m_tready;
    assign consume  = cmd.div_start || cmd.exec;
    assign s_tready = !req_valid_reg || consume;
    assign m_tvalid = out_valid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (req_valid_reg) begin
                    if (status.tick_div) begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end else if (out_free) begin
                        cmd.exec = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.out_tick = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        cmd.req_load   = s_tvalid && (!req_valid_reg || cmd.div_start || cmd.exec);
        req_valid_next = cmd.req_load || (req_valid_reg && !(cmd.div_start || cmd.exec));
        out_valid_next = cmd.exec || cmd.out_tick || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            req_valid_reg <= req_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: hdl/pfi_datapath.sv
module pfi_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [pfi_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [pfi_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic [39:0]                     s_tdata,
    input  logic [1:0]                      s_tuser,
    input  pfi_pkg::cmd_t                   cmd,
    output pfi_pkg::status_t                status,
    output logic [15:0]                     m_tdata,
    output logic                            m_tuser
);

    logic [7:0]  fade_frames_reg;
    logic [1:0]  source_mode_reg;
    logic [14:0] fixed_color_reg;
    logic [4:0]  palette_count_reg;
    logic        use_mask_reg;
    logic [15:0] palette_mask_reg;

    logic [8:0]  frame_time_reg, frame_time_next;
    logic        fade_active_reg, fade_active_next;
    logic [8:0]  blend_weight_reg, blend_weight_next;

    logic [1:0]  req_mode_reg;
    logic [7:0]  req_index_reg;
    logic [14:0] req_color_a_reg;
    logic [14:0] req_color_b_reg;

    logic [16:0] dvd_reg;
    logic [7:0]  rem_reg;
    logic [pfi_pkg::DIV_CNT_W-1:0] div_cnt_reg;

    logic [14:0] color_reg, color_next;
    logic        written_reg, written_next;
    logic        done_reg, done_next;

    logic [8:0]  time_inc;
    logic        tick_ends;
    logic [4:0]  pal_sat;
    logic        selected;
    logic [8:0]  w_sat;
    logic [8:0]  div_trial;
    logic        div_ge;
    logic [8:0]  div_diff;

    assign time_inc  = frame_time_reg + 9'd1;
    assign tick_ends = (time_inc > {1'b0, fade_frames_reg}) || (fade_frames_reg == 8'd0);

    assign status.tick_div = (req_mode_reg == pfi_pkg::MODE_TICK) && fade_active_reg
                             && !tick_ends;
    assign status.div_last = (div_cnt_reg == '0);

    assign pal_sat  = (palette_count_reg > 5'(pfi_pkg::PALETTE_COUNT_MAX))
                      ? 5'(pfi_pkg::PALETTE_COUNT_MAX) : palette_count_reg;
    assign selected = use_mask_reg
                      ? palette_mask_reg[req_index_reg[7:pfi_pkg::ENTRIES_LOG2]]
                      : ({1'b0, req_index_reg} < {pal_sat, 4'd0});
    assign w_sat    = (blend_weight_reg > pfi_pkg::WEIGHT_ONE) ? pfi_pkg::WEIGHT_ONE
                                                               : blend_weight_reg;

    assign div_trial = {rem_reg, dvd_reg[16]};
    assign div_ge    = div_trial >= {1'b0, fade_frames_reg};
    assign div_diff  = div_trial - {1'b0, fade_frames_reg};

    always_comb begin
        frame_time_next   = frame_time_reg;
        fade_active_next  = fade_active_reg;
        blend_weight_next = blend_weight_reg;
        color_next        = 15'd0;
        written_next      = 1'b0;
        if (cmd.exec) begin
            unique case (req_mode_reg)
                pfi_pkg::MODE_RESTART: begin
                    frame_time_next   = 9'd0;
                    fade_active_next  = 1'b1;
                    blend_weight_next = 9'd0;
                end
                pfi_pkg::MODE_TICK: begin
                    if (fade_active_reg) begin
                        frame_time_next  = time_inc;
                        fade_active_next = 1'b0;
                    end
                end
                pfi_pkg::MODE_BLEND: begin
                    if (fade_active_reg && selected) begin
                        written_next = 1'b1;
                        unique case (source_mode_reg)
                            pfi_pkg::SRC_FIXED_TO_PAL:
                                color_next = pfi_pkg::lerp_color(fixed_color_reg,
                                                                 req_color_b_reg, w_sat);
                            pfi_pkg::SRC_PAL_TO_FIXED:
                                color_next = pfi_pkg::lerp_color(fixed_color_reg,
                                                                 req_color_a_reg,
                                                                 pfi_pkg::WEIGHT_ONE - w_sat);
                            default:
                                color_next = pfi_pkg::lerp_color(req_color_a_reg,
                                                                 req_color_b_reg, w_sat);
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end else if (cmd.div_start) begin
            frame_time_next = time_inc;
        end else if (cmd.div_step && status.div_last) begin
            blend_weight_next = {dvd_reg[7:0], div_ge};
        end
        done_next = !fade_active_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fade_frames_reg   <= 8'd32;
            source_mode_reg   <= 2'd0;
            fixed_color_reg   <= 15'd0;
            palette_count_reg <= 5'd1;
            use_mask_reg      <= 1'b0;
            palette_mask_reg  <= 16'd0;
            frame_time_reg    <= 9'd0;
            fade_active_reg   <= 1'b0;
            blend_weight_reg  <= 9'd0;
            div_cnt_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    pfi_pkg::REG_FADE_FRAMES:   fade_frames_reg   <= cfg_wr_data[7:0];
                    pfi_pkg::REG_SOURCE_MODE:   source_mode_reg   <= cfg_wr_data[1:0];
                    pfi_pkg::REG_FIXED_COLOR:   fixed_color_reg   <= cfg_wr_data[14:0];
                    pfi_pkg::REG_PALETTE_COUNT: palette_count_reg <= cfg_wr_data[4:0];
                    pfi_pkg::REG_USE_MASK:      use_mask_reg      <= cfg_wr_data[0];
                    pfi_pkg::REG_PALETTE_MASK:  palette_mask_reg  <= cfg_wr_data[15:0];
                    default: begin
                    end
                endcase
            end
            frame_time_reg   <= frame_time_next;
            fade_active_reg  <= fade_active_next;
            blend_weight_reg <= blend_weight_next;
            if (cmd.div_start) begin
                div_cnt_reg <= pfi_pkg::DIV_CNT_W'(pfi_pkg::DIV_STEPS - 1);
            end else if (cmd.div_step) begin
                div_cnt_reg <= div_cnt_reg - pfi_pkg::DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.req_load) begin
            req_mode_reg    <= s_tuser;
            req_index_reg   <= s_tdata[7:0];
            req_color_a_reg <= s_tdata[22:8];
            req_color_b_reg <= s_tdata[37:23];
        end
        if (cmd.div_start) begin
            dvd_reg <= {time_inc, 8'd0};
            rem_reg <= 8'd0;
        end else if (cmd.div_step) begin
            dvd_reg <= {dvd_reg[15:0], div_ge};
            rem_reg <= div_ge ? div_diff[7:0] : div_trial[7:0];
        end
        if (cmd.exec || cmd.out_tick) begin
            color_reg   <= color_next;
            written_reg <= written_next;
            done_reg    <= done_next;
        end
    end

    assign m_tdata = {done_reg, color_reg};
    assign m_tuser = written_reg;

endmodule

FILE: hdl/palette_fade_interpolator_core.sv
// Palette fade engine for BGR555 colours. Requests carry a mode in s_tuser:
// restart, frame tick or blend of one palette entry; every request returns
// exactly one result. A request buffer in front of the output register lets
// the next request in while a result waits. Restart, blend, a tick while the
// fade is idle and the tick that ends the fade run from the request buffer,
// so blends stream at one entry per cycle while the output is not stalled.
// A tick that recomputes the Q.8 weight runs the bit-serial restoring divider,
// one quotient bit per cycle over 17 steps, before the next request starts.
module palette_fade_interpolator_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [pfi_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [pfi_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [39:0]                     s_tdata,  // entry_index, color_a, color_b
    input  logic [1:0]                      s_tuser,  // mode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,  // blended_color, done_res
    output logic                            m_tuser   // written
);

    pfi_pkg::cmd_t    cmd;
    pfi_pkg::status_t status;

    pfi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pfi_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cmd         (cmd),
        .status      (status),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // a written blend only happens inside an active fade
    a_written_not_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> !m_tdata[15])
        else $error("blend result flagged as done");

    a_reset_no_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    a_div_follows_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> cmd.div_step && !cmd.exec && !cmd.out_tick)
        else $error("divider not stepping after start");

    a_no_load_while_dividing: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> !cmd.exec && !cmd.out_tick && !cmd.div_start)
        else $error("result loaded while dividing");

endmodule
